>>> hdl/rse_pkg.sv
// shared types, codes and helpers for the postfix stack evaluator
// no dependencies; the evaluator, divider and checker refer to this package by scoped names
package rse_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    // fixed field widths
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 4;
    localparam int DEPTH_W = 5;
    localparam int ERR_W   = 2;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_NOP   = 4'd0,
        FN_PUSH  = 4'd1,
        FN_ADD   = 4'd2,
        FN_SUB   = 4'd3,
        FN_MUL   = 4'd4,
        FN_DIV   = 4'd5,
        FN_MOD   = 4'd6,
        FN_ABS   = 4'd7,
        FN_DUP   = 4'd8,
        FN_CLEAR = 4'd9
    } func_t;

    // error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_DIVZ  = 2'd3
    } err_t;

    // input word
    typedef struct packed {
        func_t                    func;
        logic signed [DATA_W-1:0] operand;
    } in_word_t;

    // result word
    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        err_t                     error_code;
    } out_word_t;

    // two's complement magnitude, most negative value maps to itself
    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
        mag = x[DATA_W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

>>> hdl/rpn_stack_evaluator.sv
// channel | dir | ports                 | payload
// s       | in  | s_valid s_ready s_data | rse_pkg::in_word_t (func, operand)
// m       | out | m_valid m_ready m_data | rse_pkg::out_word_t (top_value, depth, error_code)
//
// each word goes through accept, execute and publish steps; div and mod also wait
// on the 32-step iterative divider in rse_divider
// the top entry lives in a register, the entries below it in rse_stack_ram;
// binary operations read the second entry in the accept cycle
// synchronous active-low reset empties the stack; ram contents are not cleared
// a new word is taken while the previous result waits on m; a stalled m only
// holds the block in its publish step
// depends on rse_pkg, rse_stack_ram, rse_divider
module rpn_stack_evaluator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rse_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rse_pkg::out_word_t m_data
);

    localparam int W = rse_pkg::DATA_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    rse_pkg::func_t     func_reg, func_next;
    logic [W-1:0]       operand_reg, operand_next;
    logic [W-1:0]       top_reg, top_next;
    logic [rse_pkg::SP_W-1:0] sp_reg, sp_next;
    rse_pkg::out_word_t res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    rse_pkg::out_word_t m_data_reg, m_data_next;

    logic [rse_pkg::ADDR_W-1:0] rd_addr;
    logic [rse_pkg::ADDR_W-1:0] wr_addr;
    logic [W-1:0]               rd_data;
    logic                       wr_en;
    logic                       div_start;
    logic                       div_done;
    logic [W-1:0]               div_quo;
    logic [W-1:0]               div_rem;
    logic                       finish;
    rse_pkg::err_t              err;
    logic                       full;

    // second entry sits at sp-2, the slot for the current top at sp-1
    assign rd_addr = rse_pkg::ADDR_W'(sp_reg - rse_pkg::SP_W'(2));
    assign wr_addr = rse_pkg::ADDR_W'(sp_reg - rse_pkg::SP_W'(1));
    assign full    = (sp_reg == rse_pkg::SP_W'(rse_pkg::STACK_DEPTH));

    rse_stack_ram #(
        .DATA_W (W),
        .DEPTH  (rse_pkg::STACK_DEPTH),
        .ADDR_W (rse_pkg::ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rse_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (rse_pkg::mag(rd_data)),
        .divisor   (rse_pkg::mag(top_reg)),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // sequencer and stack update
    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        operand_next = operand_reg;
        top_next     = top_reg;
        sp_next      = sp_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        wr_en        = 1'b0;
        div_start    = 1'b0;
        finish       = 1'b0;
        err          = rse_pkg::ERR_OK;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next    = s_data.func;
                    operand_next = s_data.operand;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                finish = 1'b1;
                unique case (func_reg) inside
                    rse_pkg::FN_PUSH: begin
                        if (full) begin
                            err = rse_pkg::ERR_OVER;
                        end else begin
                            wr_en    = (sp_reg != '0);
                            top_next = operand_reg;
                            sp_next  = sp_reg + 1'b1;
                        end
                    end
                    rse_pkg::FN_ADD, rse_pkg::FN_SUB, rse_pkg::FN_MUL: begin
                        if (sp_reg < rse_pkg::SP_W'(2)) begin
                            err = rse_pkg::ERR_UNDER;
                        end else begin
                            if (func_reg == rse_pkg::FN_ADD) begin
                                top_next = rd_data + top_reg;
                            end else if (func_reg == rse_pkg::FN_SUB) begin
                                top_next = rd_data - top_reg;
                            end else begin
                                top_next = rd_data * top_reg;
                            end
                            sp_next = sp_reg - 1'b1;
                        end
                    end
                    rse_pkg::FN_DIV, rse_pkg::FN_MOD: begin
                        if (sp_reg < rse_pkg::SP_W'(2)) begin
                            err = rse_pkg::ERR_UNDER;
                        end else if (top_reg == '0) begin
                            err = rse_pkg::ERR_DIVZ;
                        end else begin
                            div_start  = 1'b1;
                            finish     = 1'b0;
                            state_next = S_DIV;
                        end
                    end
                    rse_pkg::FN_ABS: begin
                        if (sp_reg == '0) begin
                            err = rse_pkg::ERR_UNDER;
                        end else begin
                            top_next = rse_pkg::mag(top_reg);
                        end
                    end
                    rse_pkg::FN_DUP: begin
                        if (sp_reg == '0) begin
                            err = rse_pkg::ERR_UNDER;
                        end else if (full) begin
                            err = rse_pkg::ERR_OVER;
                        end else begin
                            wr_en   = 1'b1;
                            sp_next = sp_reg + 1'b1;
                        end
                    end
                    rse_pkg::FN_CLEAR: begin
                        sp_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                // ram read data and top stay put while the divider runs
                if (div_done) begin
                    finish = 1'b1;
                    if (func_reg == rse_pkg::FN_DIV) begin
                        top_next = (rd_data[W-1] ^ top_reg[W-1]) ? (~div_quo + 1'b1)
                                                                 : div_quo;
                    end else begin
                        top_next = rd_data[W-1] ? (~div_rem + 1'b1) : div_rem;
                    end
                    sp_next = sp_reg - 1'b1;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // capture the result word
        if (finish) begin
            res_next.top_value  = (sp_next == '0) ? '0 : top_next;
            res_next.depth      = rse_pkg::DEPTH_W'(sp_next);
            res_next.error_code = err;
            state_next          = S_OUT;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg    <= func_next;
        operand_reg <= operand_next;
        top_reg     <= top_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/rse_stack_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module rse_stack_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/rse_divider.sv
// iterative unsigned restoring divider, one quotient bit per cycle
// depends on rse_pkg for the data width
module rse_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rse_pkg::DATA_W-1:0] dividend,
    input  logic [rse_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [rse_pkg::DATA_W-1:0] quotient,
    output logic [rse_pkg::DATA_W-1:0] remainder
);

    localparam int W      = rse_pkg::DATA_W;
    localparam int ITER_W = $clog2(W);

    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      quo_reg, quo_next;
    logic [W-1:0]      den_reg, den_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [W:0]        trial;

    // one restoring step
    always_comb begin
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = ITER_W'(W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/rse_checker.sv
// port-level checks on the result words of rpn_stack_evaluator, with bind
// depends on rse_pkg and rpn_stack_evaluator
module rse_port_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input rse_pkg::out_word_t m_data
);

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // a waiting result word stays valid and unchanged
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result word dropped or changed while waiting");

    // empty stack shows zero on top
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.depth == '0) |-> m_data.top_value == '0)
        else $error("nonzero top on empty stack");

    // overflow only with a full stack
    a_over_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error_code == rse_pkg::ERR_OVER)
            |-> m_data.depth == rse_pkg::DEPTH_W'(rse_pkg::STACK_DEPTH))
        else $error("overflow reported below full depth");

    // underflow only with fewer than two entries
    a_under_shallow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error_code == rse_pkg::ERR_UNDER)
            |-> m_data.depth < rse_pkg::DEPTH_W'(2))
        else $error("underflow reported with two or more entries");

endmodule

bind rpn_stack_evaluator rse_port_checker u_rse_port_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
